FILE: rtl/wfmrt_pkg.sv
`timescale 1ns / 1ps

package wfmrt_pkg;

	// default table geometry
	localparam int MAX_RULES_DEF         = 32;
	localparam int PRODUCTS_PER_RULE_DEF = 4;
	localparam int MAX_ID_ENTRIES_DEF    = 32;

	// field widths
	localparam int REQ_W    = 3;
	localparam int IDX_W    = 5;
	localparam int SLOT_W   = 2;
	localparam int FAM_W    = 3;
	localparam int CONN_W   = 2;
	localparam int IDENT_W  = 8;
	localparam int ID_W     = 16;
	localparam int LEN_W    = 16;
	localparam int CNT_W    = 6;

	// request codes
	localparam logic [REQ_W-1:0] REQ_WR_ROW    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_WR_PROD   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_WR_ID     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_LK_REPORT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_LK_IDS    = 3'd4;
	localparam logic [REQ_W-1:0] REQ_FAM_IDS   = 3'd5;

	// APB register map (word select bit of paddr)
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_ROWS_IN_USE = 1'b0;
	localparam logic REG_IDS_IN_USE  = 1'b1;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [IDX_W-1:0]   entry_index;
		logic [SLOT_W-1:0]  product_slot;
		logic [FAM_W-1:0]   family_code;
		logic [CONN_W-1:0]  conn_type;
		logic [IDENT_W-1:0] report_ident;
		logic               check_report_id;
		logic [ID_W-1:0]    vendor_id;
		logic [ID_W-1:0]    product_id;
		logic [LEN_W-1:0]   report_length;
		logic [LEN_W-1:0]   length_min;
		logic [LEN_W-1:0]   length_max;
	} req_item_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] row_found;
		logic [FAM_W-1:0] family_out;
	} rsp_item_t;

	typedef struct packed {
		logic [FAM_W-1:0]   family;
		logic [CONN_W-1:0]  conn;
		logic [IDENT_W-1:0] ident;
		logic [LEN_W-1:0]   len_lo;
		logic [LEN_W-1:0]   len_hi;
	} row_hdr_t;

	typedef struct packed {
		logic [ID_W-1:0]  vendor;
		logic [ID_W-1:0]  product;
		logic [FAM_W-1:0] family;
	} id_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic scan_clr;
		logic scan_run;
		logic mode_row;
		logic take;
		logic load_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             fam_zero;
		logic             found;
		logic             exhausted;
		logic             out_free;
	} dp_sts_t;

endpackage

FILE: rtl/wfmrt_if.sv
`timescale 1ns / 1ps

interface wfmrt_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [wfmrt_pkg::REQ_W-1:0]          req_type;
	logic [wfmrt_pkg::IDX_W-1:0]          entry_index;
	logic [wfmrt_pkg::SLOT_W-1:0]         product_slot;
	logic [wfmrt_pkg::FAM_W-1:0]          family_code;
	logic [wfmrt_pkg::CONN_W-1:0]         conn_type;
	logic [wfmrt_pkg::IDENT_W-1:0]        report_ident;
	logic                                 check_report_id;
	logic [wfmrt_pkg::ID_W-1:0]           vendor_id;
	logic [wfmrt_pkg::ID_W-1:0]           product_id;
	logic [wfmrt_pkg::LEN_W-1:0]          report_length;
	logic [wfmrt_pkg::LEN_W-1:0]          length_min;
	logic [wfmrt_pkg::LEN_W-1:0]          length_max;

	modport source (
		output valid, req_type, entry_index, product_slot, family_code, conn_type,
		       report_ident, check_report_id, vendor_id, product_id, report_length,
		       length_min, length_max,
		input  ready
	);

	modport sink (
		input  valid, req_type, entry_index, product_slot, family_code, conn_type,
		       report_ident, check_report_id, vendor_id, product_id, report_length,
		       length_min, length_max,
		output ready
	);
endinterface

interface wfmrt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [wfmrt_pkg::IDX_W-1:0]  row_found;
	logic [wfmrt_pkg::FAM_W-1:0]  family_out;

	modport source (
		output valid, hit, row_found, family_out,
		input  ready
	);

	modport sink (
		input  valid, hit, row_found, family_out,
		output ready
	);
endinterface

FILE: rtl/wfmrt_ram.sv
`timescale 1ns / 1ps

module wfmrt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/wfmrt_ctrl.sv
`timescale 1ns / 1ps

module wfmrt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wfmrt_pkg::dp_sts_t  sts,
	output wfmrt_pkg::dp_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_ID     = 3'd2;
	localparam logic [2:0] S_ROW    = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.req_type == wfmrt_pkg::REQ_LK_REPORT && !sts.fam_zero) begin
					cmd.scan_clr = 1'b1;
					state_d = S_ROW;
				end else if (sts.req_type inside {wfmrt_pkg::REQ_LK_REPORT,
						wfmrt_pkg::REQ_LK_IDS, wfmrt_pkg::REQ_FAM_IDS}) begin
					cmd.scan_clr = 1'b1;
					state_d = S_ID;
				end else begin
					state_d = S_DONE;
				end
			end
			S_ID: begin
				cmd.scan_run = 1'b1;
				if (sts.found || sts.exhausted) begin
					cmd.take = sts.found;
					if (sts.req_type == wfmrt_pkg::REQ_FAM_IDS) begin
						state_d = S_DONE;
					end else begin
						cmd.scan_clr = 1'b1;
						state_d = S_ROW;
					end
				end
			end
			S_ROW: begin
				cmd.scan_run = 1'b1;
				cmd.mode_row = 1'b1;
				if (sts.found || sts.exhausted) begin
					cmd.take = sts.found;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: rtl/wfmrt_dp.sv
`timescale 1ns / 1ps

module wfmrt_dp #(
	parameter int MAX_RULES         = wfmrt_pkg::MAX_RULES_DEF,
	parameter int PRODUCTS_PER_RULE = wfmrt_pkg::PRODUCTS_PER_RULE_DEF,
	parameter int MAX_ID_ENTRIES    = wfmrt_pkg::MAX_ID_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wfmrt_pkg::req_item_t          item,
	input  logic [wfmrt_pkg::CNT_W-1:0]   rows_in_use,
	input  logic [wfmrt_pkg::CNT_W-1:0]   ids_in_use,
	input  logic                          out_ready,
	output logic                          out_valid,
	output wfmrt_pkg::rsp_item_t          out_item,
	input  wfmrt_pkg::dp_cmd_t            cmd,
	output wfmrt_pkg::dp_sts_t            sts
);
	localparam int MAXD   = (MAX_RULES > MAX_ID_ENTRIES) ? MAX_RULES : MAX_ID_ENTRIES;
	localparam int SCAN_W = $clog2(MAXD + 1);
	localparam int RAW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int IAW    = (MAX_ID_ENTRIES > 1) ? $clog2(MAX_ID_ENTRIES) : 1;
	localparam int HDR_W  = $bits(wfmrt_pkg::row_hdr_t);
	localparam int ENT_W  = $bits(wfmrt_pkg::id_entry_t);

	wfmrt_pkg::req_item_t          req_q;
	logic [wfmrt_pkg::FAM_W-1:0]   family_q;
	logic                          hit_q;
	logic [wfmrt_pkg::IDX_W-1:0]   row_q;
	logic [SCAN_W-1:0]             scan_q;
	logic [SCAN_W-1:0]             idx_s1;
	logic                          v_s1;
	logic                          out_valid_q;
	wfmrt_pkg::rsp_item_t          out_q;

	logic [8:0]          idx9;
	logic                wr_row_ok;
	logic                wr_id_ok;
	logic [8:0]          rows_c9;
	logic [8:0]          ids_c9;
	logic [SCAN_W-1:0]   limit;
	logic                more;

	wfmrt_pkg::row_hdr_t   hdr_wr;
	wfmrt_pkg::row_hdr_t   hdr_rd;
	wfmrt_pkg::id_entry_t  ent_wr;
	wfmrt_pkg::id_entry_t  ent_rd;
	logic [HDR_W-1:0]      hdr_rd_raw;
	logic [ENT_W-1:0]      ent_rd_raw;
	logic [wfmrt_pkg::ID_W-1:0] prod_rd [PRODUCTS_PER_RULE];

	logic                       chk_id;
	logic [wfmrt_pkg::LEN_W-1:0] len_eff;
	logic                       rule_hit;
	logic                       id_match;
	logic                       fam_ok;
	logic                       ident_ok;
	logic                       conn_ok;
	logic                       len_ok;
	logic                       prod_ok;
	logic                       prod_any;

	// table writes happen on the accepting edge
	assign idx9      = {4'b0000, item.entry_index};
	assign wr_row_ok = cmd.capture && (idx9 < 9'(MAX_RULES));
	assign wr_id_ok  = cmd.capture && (idx9 < 9'(MAX_ID_ENTRIES))
	                   && (item.req_type == wfmrt_pkg::REQ_WR_ID);

	assign hdr_wr = '{family: item.family_code, conn: item.conn_type,
	                  ident: item.report_ident, len_lo: item.length_min,
	                  len_hi: item.length_max};
	assign ent_wr = '{vendor: item.vendor_id, product: item.product_id,
	                  family: item.family_code};

	wfmrt_ram #(.WIDTH(HDR_W), .DEPTH(MAX_RULES)) u_hdr_ram (
		.clk   (clk),
		.we    (wr_row_ok && (item.req_type == wfmrt_pkg::REQ_WR_ROW)),
		.waddr (idx9[RAW-1:0]),
		.wdata (hdr_wr),
		.raddr (scan_q[RAW-1:0]),
		.rdata (hdr_rd_raw)
	);
	assign hdr_rd = hdr_rd_raw;

	for (genvar s = 0; s < PRODUCTS_PER_RULE; s++) begin : g_prod
		wfmrt_ram #(.WIDTH(wfmrt_pkg::ID_W), .DEPTH(MAX_RULES)) u_prod_ram (
			.clk   (clk),
			.we    (wr_row_ok && (item.req_type == wfmrt_pkg::REQ_WR_PROD)
			        && ({2'b00, item.product_slot} == 4'(s))),
			.waddr (idx9[RAW-1:0]),
			.wdata (item.product_id),
			.raddr (scan_q[RAW-1:0]),
			.rdata (prod_rd[s])
		);
	end

	wfmrt_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ID_ENTRIES)) u_id_ram (
		.clk   (clk),
		.we    (wr_id_ok),
		.waddr (idx9[IAW-1:0]),
		.wdata (ent_wr),
		.raddr (scan_q[IAW-1:0]),
		.rdata (ent_rd_raw)
	);
	assign ent_rd = ent_rd_raw;

	// scan limit: register value clamped to table depth
	assign rows_c9 = (9'(rows_in_use) > 9'(MAX_RULES)) ? 9'(MAX_RULES) : 9'(rows_in_use);
	assign ids_c9  = (9'(ids_in_use) > 9'(MAX_ID_ENTRIES)) ?
	                 9'(MAX_ID_ENTRIES) : 9'(ids_in_use);
	assign limit   = cmd.mode_row ? SCAN_W'(rows_c9) : SCAN_W'(ids_c9);
	assign more    = scan_q < limit;

	// id entry compare
	assign id_match = (ent_rd.vendor == req_q.vendor_id)
	                  && (ent_rd.product == '0 || ent_rd.product == req_q.product_id);

	// row compare
	assign chk_id  = (req_q.req_type == wfmrt_pkg::REQ_LK_REPORT) && req_q.check_report_id;
	assign len_eff = (req_q.req_type == wfmrt_pkg::REQ_LK_REPORT) ? req_q.report_length : '0;

	always_comb begin
		prod_any = 1'b0;
		for (int s = 0; s < PRODUCTS_PER_RULE; s++) begin
			if (prod_rd[s] == req_q.product_id) begin
				prod_any = 1'b1;
			end
		end
	end

	assign fam_ok   = hdr_rd.family == family_q;
	assign ident_ok = !chk_id || (hdr_rd.ident == req_q.report_ident);
	assign conn_ok  = (hdr_rd.conn == '0) || (req_q.conn_type == '0)
	                  || (hdr_rd.conn == req_q.conn_type);
	assign len_ok   = (len_eff == '0) || (hdr_rd.len_lo == '0 && hdr_rd.len_hi == '0)
	                  || (((hdr_rd.len_lo == '0) || (len_eff >= hdr_rd.len_lo))
	                      && ((hdr_rd.len_hi == '0) || (len_eff <= hdr_rd.len_hi)));
	assign prod_ok  = (req_q.product_id == '0) || (prod_rd[0] == '0) || prod_any;
	assign rule_hit = fam_ok && ident_ok && conn_ok && len_ok && prod_ok;

	assign sts.req_type  = req_q.req_type;
	assign sts.fam_zero  = req_q.family_code == '0;
	assign sts.found     = v_s1 && (cmd.mode_row ? rule_hit : id_match);
	assign sts.exhausted = !v_s1 && !more;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= item;
			family_q <= (item.req_type == wfmrt_pkg::REQ_LK_REPORT) ? item.family_code : '0;
			hit_q    <= 1'b0;
			row_q    <= '0;
		end else if (cmd.take) begin
			if (cmd.mode_row) begin
				hit_q <= 1'b1;
				row_q <= wfmrt_pkg::IDX_W'(idx_s1);
			end else begin
				family_q <= ent_rd.family;
			end
		end
		if (cmd.scan_run) begin
			idx_s1 <= scan_q;
		end
		if (cmd.load_out) begin
			out_q <= '{hit: hit_q, row_found: row_q, family_out: family_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_clr) begin
				scan_q <= '0;
				v_s1   <= 1'b0;
			end else if (cmd.scan_run) begin
				v_s1 <= more;
				if (more) begin
					scan_q <= scan_q + SCAN_W'(1);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule

FILE: rtl/wildcard_first_match_rule_table_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Kind            Transfer when
// req       in   valid/ready     req.valid && req.ready  (one request item)
// rsp       out  valid/ready     rsp.valid && rsp.ready  (one result item)
// apb       in   APB-style cfg   psel && penable && pwrite (pready tied high)
//
// Sequence: a write or unused request passes DECODE and DONE before the next ready.
// A lookup walks the ID table, the rule table or both (a report lookup with a
// nonzero family skips the IDs, a family-ID lookup skips the rows), one entry
// per cycle out of their registered-read RAMs; each walk stops at its first match.
// Reset: arst_n clears the controller, scan counter and output valid; table RAMs
// hold no reset and must be written before they are searched.
// Stalls: a finished result waits in the output register while the next request
// is taken; only loading a new result waits on rsp.ready.

module wildcard_first_match_rule_table_top #(
	parameter int MAX_RULES         = wfmrt_pkg::MAX_RULES_DEF,
	parameter int PRODUCTS_PER_RULE = wfmrt_pkg::PRODUCTS_PER_RULE_DEF,
	parameter int MAX_ID_ENTRIES    = wfmrt_pkg::MAX_ID_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	wfmrt_req_if.sink                       req,
	wfmrt_rsp_if.source                     rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wfmrt_pkg::PADDR_W-1:0]   paddr,
	input  logic [wfmrt_pkg::PDATA_W-1:0]   pwdata,
	output logic [wfmrt_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready
);
	wfmrt_pkg::req_item_t          item;
	wfmrt_pkg::rsp_item_t          out_item;
	wfmrt_pkg::dp_cmd_t            cmd;
	wfmrt_pkg::dp_sts_t            sts;
	logic                          in_ready;
	logic                          out_valid;
	logic [wfmrt_pkg::CNT_W-1:0]   rows_in_use_q;
	logic [wfmrt_pkg::CNT_W-1:0]   ids_in_use_q;
	logic                          cfg_wr;

	// gather the request payload into one item
	assign item = '{
		req_type:        req.req_type,
		entry_index:     req.entry_index,
		product_slot:    req.product_slot,
		family_code:     req.family_code,
		conn_type:       req.conn_type,
		report_ident:    req.report_ident,
		check_report_id: req.check_report_id,
		vendor_id:       req.vendor_id,
		product_id:      req.product_id,
		report_length:   req.report_length,
		length_min:      req.length_min,
		length_max:      req.length_max
	};
	assign req.ready = in_ready;

	assign rsp.valid      = out_valid;
	assign rsp.hit        = out_item.hit;
	assign rsp.row_found  = out_item.row_found;
	assign rsp.family_out = out_item.family_out;

	// configuration registers; paddr[2] selects the word, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= '0;
			ids_in_use_q  <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				wfmrt_pkg::REG_ROWS_IN_USE: rows_in_use_q <= pwdata[wfmrt_pkg::CNT_W-1:0];
				wfmrt_pkg::REG_IDS_IN_USE:  ids_in_use_q  <= pwdata[wfmrt_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			wfmrt_pkg::REG_ROWS_IN_USE: prdata = wfmrt_pkg::PDATA_W'(rows_in_use_q);
			wfmrt_pkg::REG_IDS_IN_USE:  prdata = wfmrt_pkg::PDATA_W'(ids_in_use_q);
			default:                    prdata = '0;
		endcase
	end

	// sequencer: accept, decode, walk IDs, walk rows, hand off the result
	wfmrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// tables, compare logic, scan counter and output register
	wfmrt_dp #(
		.MAX_RULES         (MAX_RULES),
		.PRODUCTS_PER_RULE (PRODUCTS_PER_RULE),
		.MAX_ID_ENTRIES    (MAX_ID_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.rows_in_use (rows_in_use_q),
		.ids_in_use  (ids_in_use_q),
		.out_ready   (rsp.ready),
		.out_valid   (out_valid),
		.out_item    (out_item),
		.cmd         (cmd),
		.sts         (sts)
	);
endmodule

FILE: rtl/wfmrt_checker.sv
`timescale 1ns / 1ps

module wfmrt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_hit,
	input logic [wfmrt_pkg::IDX_W-1:0] rsp_row_found,
	input logic [wfmrt_pkg::FAM_W-1:0] rsp_family_out
);
	// a held result keeps its value until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
		&& $stable(rsp_row_found) && $stable(rsp_family_out))
		else $error("result changed while stalled");

	// a miss never reports a row
	a_miss_row: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_row_found == '0)
		else $error("row index on a miss");

	// one request in flight: ready drops after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// no result can appear the cycle right after a request transfer
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result too early");
endmodule

bind wildcard_first_match_rule_table_top wfmrt_checker u_wfmrt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_hit        (rsp.hit),
	.rsp_row_found  (rsp.row_found),
	.rsp_family_out (rsp.family_out)
);
